// File: src/tbrt_pkg.sv
`timescale 1ns / 1ps

package tbrt_pkg;

  // Item selector codes
  typedef enum logic [1:0] {
    FUNC_FAIL  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  // Table geometry and limits
  localparam int unsigned NumIntervals = 7;
  localparam int unsigned IdxW         = 3;
  localparam int unsigned SecW         = 22;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned AddrW        = 5;
  localparam int unsigned DataW        = 32;

  localparam logic [SecW-1:0]  MaxIntervalS = SecW'(32'h7FFF_FFFF / 32'd1000);
  localparam logic [TimeW-1:0] MsPerS       = TimeW'(1000);

  // Register indexes (byte address = 4 * index)
  localparam logic [IdxW-1:0] RegEntryCount = 3'd0;
  localparam logic [IdxW-1:0] RegInterval0  = 3'd1;

  // Reset contents of the interval table, entry 0 in the low bits
  localparam logic [IdxW-1:0] EntryCountReset = 3'd6;
  localparam logic [NumIntervals-1:0][SecW-1:0] IntervalReset = {
    22'd0, 22'd20, 22'd15, 22'd10, 22'd5, 22'd3, 22'd1
  };

  // Configuration seen by the datapath
  typedef struct packed {
    logic [IdxW-1:0]                        entry_count;
    logic [NumIntervals-1:0][SecW-1:0]      interval;
  } cfg_t;

endpackage

// File: src/tbrt_regs.sv
`timescale 1ns / 1ps

module tbrt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbrt_pkg::AddrW-1:0]    paddr,
  input  logic [tbrt_pkg::DataW-1:0]    pwdata,
  output logic [tbrt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output tbrt_pkg::cfg_t                cfg_o
);

  logic [tbrt_pkg::IdxW-1:0] reg_idx;
  logic [tbrt_pkg::IdxW-1:0] tbl_idx;
  logic                      wr_en;
  tbrt_pkg::cfg_t            cfg_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign tbl_idx = reg_idx - tbrt_pkg::RegInterval0;
  assign wr_en   = psel & penable & pwrite;

  // Register writes on the access phase of a write transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count <= tbrt_pkg::EntryCountReset;
      cfg_q.interval    <= tbrt_pkg::IntervalReset;
    end else if (wr_en) begin
      if (reg_idx == tbrt_pkg::RegEntryCount) begin
        cfg_q.entry_count <= pwdata[tbrt_pkg::IdxW-1:0];
      end else begin
        cfg_q.interval[tbl_idx] <= pwdata[tbrt_pkg::SecW-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (reg_idx == tbrt_pkg::RegEntryCount) begin
      prdata = tbrt_pkg::DataW'(cfg_q.entry_count);
    end else begin
      prdata = tbrt_pkg::DataW'(cfg_q.interval[tbl_idx]);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/table_backoff_retry_timer_unit.sv
`timescale 1ns / 1ps

// Table-driven retry back-off timer.
// Input channel (in_valid_i / in_stall_o) carries func and now_ms. A fail item
// arms a deadline now_ms + interval*1000 from the table entry at the attempt
// index and advances that index; a reset item clears the index and disarms; a
// query item reports due and the milliseconds that remain.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item, in order.
// Path: each item sits in the input register, then in the result register,
// which drives out_valid_o.
// Throughput: one item per cycle while out_stall_i is low; the lookup, x1000
// and 32-bit add/compare sit between the two registers, and state updates as
// an item moves into the result register, so the next item sees it at once.
// When the receiver stalls, the result holds and the input register fills;
// in_stall_o rises only when both registers are occupied and blocked.
// Reset: pipeline empty, attempt index 0, timer disarmed, table back to its
// default of six entries (1, 3, 5, 10, 15, 20 s). The APB port (pready always
// high) writes entry_count at 0x00 and interval_0..6 at 0x04..0x1C; write only
// while the block is idle.
module table_backoff_retry_timer_unit #(
  parameter int unsigned TABLE_MAX = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbrt_pkg::AddrW-1:0]    paddr,
  input  logic [tbrt_pkg::DataW-1:0]    pwdata,
  output logic [tbrt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_func_i,
  input  logic [tbrt_pkg::TimeW-1:0]    in_now_ms_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tbrt_pkg::TimeW-1:0]    out_armed_deadline_o,
  output logic                          out_is_due_o,
  output logic [tbrt_pkg::TimeW-1:0]    out_remain_ms_o
);

  localparam int unsigned IdxW  = tbrt_pkg::IdxW;
  localparam int unsigned SecW  = tbrt_pkg::SecW;
  localparam int unsigned TimeW = tbrt_pkg::TimeW;
  localparam logic [IdxW-1:0] TableMaxC = IdxW'(TABLE_MAX);

  tbrt_pkg::cfg_t cfg;

  tbrt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control
  logic             s1_valid_q;
  logic [1:0]       s1_func_q;
  logic [TimeW-1:0] s1_now_q;
  logic             out_valid_q;
  logic             adv;
  logic             s1_load;
  logic             do_step;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~adv;
  assign s1_load    = in_valid_i & ~in_stall_o;
  assign do_step    = s1_valid_q & adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv | ~s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_func_q <= in_func_i;
      s1_now_q  <= in_now_ms_i;
    end
  end

  // Timer state
  logic [IdxW-1:0]  attempt_q, attempt_d;
  logic [TimeW-1:0] deadline_q, deadline_d;

  // Datapath signals
  logic [IdxW-1:0]  cnt_used;
  logic [IdxW-1:0]  rd_idx;
  logic [SecW-1:0]  sec_raw;
  logic [SecW-1:0]  sec_c;
  logic [TimeW-1:0] ms;
  logic [TimeW-1:0] dl_sum;
  logic [TimeW-1:0] dl_arm;
  logic [TimeW-1:0] diff;
  logic [TimeW-1:0] res_deadline;
  logic             res_due;
  logic [TimeW-1:0] res_remain;

  // Interval lookup, clamp and conversion to milliseconds
  assign cnt_used = (cfg.entry_count > TableMaxC) ? TableMaxC : cfg.entry_count;
  assign rd_idx   = (attempt_q < cnt_used) ? attempt_q : (cnt_used - 3'd1);
  assign sec_raw  = cfg.interval[rd_idx];
  assign sec_c    = (sec_raw > tbrt_pkg::MaxIntervalS) ? tbrt_pkg::MaxIntervalS : sec_raw;
  assign ms       = (cnt_used == '0) ? '0 : (TimeW'(sec_c) * tbrt_pkg::MsPerS);
  assign dl_sum   = s1_now_q + ms;
  assign dl_arm   = (dl_sum == '0) ? TimeW'(1) : dl_sum;
  assign diff     = s1_now_q - deadline_q;

  // Per-item result and next state
  always_comb begin
    attempt_d    = attempt_q;
    deadline_d   = deadline_q;
    res_deadline = '0;
    res_due      = 1'b0;
    res_remain   = '0;
    case (s1_func_q)
      tbrt_pkg::FUNC_FAIL: begin
        if ((cnt_used > 3'd1) && (attempt_q < (cnt_used - 3'd1))) begin
          attempt_d = attempt_q + 3'd1;
        end
        deadline_d   = dl_arm;
        res_deadline = (ms == '0) ? '0 : dl_arm;
      end
      tbrt_pkg::FUNC_RESET: begin
        attempt_d  = '0;
        deadline_d = '0;
      end
      tbrt_pkg::FUNC_QUERY: begin
        if (deadline_q != '0) begin
          if (!diff[TimeW-1]) begin
            res_due = 1'b1;
          end else begin
            res_remain = deadline_q - s1_now_q;
          end
        end
      end
      default: begin
        // unused selector: no state change, result of zeros
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attempt_q  <= '0;
      deadline_q <= '0;
    end else if (do_step) begin
      attempt_q  <= attempt_d;
      deadline_q <= deadline_d;
    end
  end

  // Result register
  logic [TimeW-1:0] out_deadline_q;
  logic             out_due_q;
  logic [TimeW-1:0] out_remain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      out_deadline_q <= res_deadline;
      out_due_q      <= res_due;
      out_remain_q   <= res_remain;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_armed_deadline_o = out_deadline_q;
  assign out_is_due_o         = out_due_q;
  assign out_remain_ms_o      = out_remain_q;

  // Checks
  a_attempt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    attempt_q < TableMaxC || attempt_q == '0)
    else $error("attempt index beyond table limit");

  a_due_no_remain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_due_q |-> out_remain_q == '0)
    else $error("due result carries remaining time");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline slot");

  a_fail_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step && s1_func_q == tbrt_pkg::FUNC_FAIL |=> deadline_q != '0)
    else $error("fail item left timer disarmed");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdxW         = tbrt_pkg::IdxW;
  localparam int unsigned SecW         = tbrt_pkg::SecW;
  localparam int unsigned TimeW        = tbrt_pkg::TimeW;
  localparam int unsigned AddrW        = tbrt_pkg::AddrW;
  localparam int unsigned DataW        = tbrt_pkg::DataW;
  localparam int unsigned NumIntervals = tbrt_pkg::NumIntervals;

  localparam int unsigned TableMax     = 7;
  localparam logic [1:0]  FuncUnused   = 2'd3;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned NumPhases    = 7;
  localparam logic [SecW-1:0] SecFieldMax = '1;

  // One result of the timer
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic             due;
    logic [TimeW-1:0] remain;
  } timer_reply_t;

  // Shadow of the timer state plus the queue of replies it predicts
  class backoff_scoreboard;
    logic [IdxW-1:0]  entry_count;
    logic [SecW-1:0]  interval [NumIntervals];
    logic [IdxW-1:0]  attempt;
    logic [TimeW-1:0] deadline;
    timer_reply_t     pending_replies[$];
    int               errors;

    function new();
      entry_count = tbrt_pkg::EntryCountReset;
      for (int i = 0; i < NumIntervals; i++) interval[i] = tbrt_pkg::IntervalReset[i];
      attempt  = '0;
      deadline = '0;
      errors   = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [DataW-1:0] value);
      if (idx == tbrt_pkg::RegEntryCount) begin
        entry_count = value[IdxW-1:0];
      end else if (idx < tbrt_pkg::RegInterval0 + NumIntervals) begin
        interval[idx - tbrt_pkg::RegInterval0] = value[SecW-1:0];
      end
    endfunction

    // Called on every input transfer; updates the shadow state
    function void note_event(logic [1:0] func, logic [TimeW-1:0] now);
      timer_reply_t     r;
      logic [IdxW-1:0]  used;
      logic [IdxW-1:0]  sel;
      logic [SecW-1:0]  sec;
      logic [TimeW-1:0] ms;
      logic [TimeW-1:0] diff;
      r = '0;
      case (func)
        tbrt_pkg::FUNC_FAIL: begin
          used = (entry_count > TableMax) ? IdxW'(TableMax) : entry_count;
          ms   = '0;
          if (used != '0) begin
            // index clamps to the last entry in use
            sel = (attempt < used) ? attempt : used - 1'b1;
            sec = interval[sel];
            if (sec > tbrt_pkg::MaxIntervalS) sec = tbrt_pkg::MaxIntervalS;
            ms = TimeW'(sec) * tbrt_pkg::MsPerS;
          end
          if (used > 1 && attempt < used - 1'b1) attempt = attempt + 1'b1;
          deadline = now + ms;
          // zero means disarmed, so a deadline landing there moves to 1
          if (deadline == '0) deadline = 1;
          r.deadline = (ms == '0) ? '0 : deadline;
        end
        tbrt_pkg::FUNC_RESET: begin
          attempt  = '0;
          deadline = '0;
        end
        tbrt_pkg::FUNC_QUERY: begin
          if (deadline != '0) begin
            diff = now - deadline;
            if (!diff[TimeW-1]) r.due = 1'b1;
            else r.remain = deadline - now;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(timer_reply_t got);
      timer_reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("result with nothing pending: deadline %h due %b remain %h",
               got.deadline, got.due, got.remain);
        errors++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.deadline !== exp.deadline) begin
        $error("armed_deadline: expected %h, actual %h", exp.deadline, got.deadline);
        errors++;
      end
      if (got.due !== exp.due) begin
        $error("is_due: expected %b, actual %b", exp.due, got.due);
        errors++;
      end
      if (got.remain !== exp.remain) begin
        $error("remain_ms: expected %h, actual %h", exp.remain, got.remain);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        in_func_i;
  logic [TimeW-1:0]  in_now_ms_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [TimeW-1:0]  out_armed_deadline_o;
  logic              out_is_due_o;
  logic [TimeW-1:0]  out_remain_ms_o;

  backoff_scoreboard sb;
  int                gap_pct;
  int                stall_pct;
  bit                calm;
  logic [TimeW-1:0]  clock_ms;
  int unsigned       quiet_cycles;

  table_backoff_retry_timer_unit #(
    .TABLE_MAX(TableMax)
  ) u_top (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_func_i           (in_func_i),
    .in_now_ms_i         (in_now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_armed_deadline_o(out_armed_deadline_o),
    .out_is_due_o        (out_is_due_o),
    .out_remain_ms_o     (out_remain_ms_o)
  );

  always #5 clk = ~clk;

  // Result side: check every output transfer
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(timer_reply_t'({out_armed_deadline_o, out_is_due_o, out_remain_ms_o}));
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 19);
        out_stall_i = 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // One input transfer, with an optional gap ahead of it
  task automatic send(logic [1:0] func, logic [TimeW-1:0] now);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i  = 1'b1;
    in_func_i   = func;
    in_now_ms_i = now;
    do @(posedge clk); while (in_stall_o);
    sb.note_event(func, now);
  endtask

  // Drop valid and wait for every pending reply
  task automatic wait_idle();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(int unsigned idx, logic [DataW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'(idx * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [SecW-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return tbrt_pkg::MaxIntervalS;
      2:       return tbrt_pkg::MaxIntervalS + 1'b1;
      3:       return SecFieldMax;
      4:       return SecW'($urandom);
      default: return SecW'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic load_table(logic [IdxW-1:0] count, bit all_max);
    write_reg(32'(tbrt_pkg::RegEntryCount), DataW'(count));
    for (int i = 0; i < NumIntervals; i++) begin
      write_reg(32'(tbrt_pkg::RegInterval0) + 32'(i),
                DataW'(all_max ? SecFieldMax : pick_interval()));
    end
  endtask

  // Mostly fails and queries around a running clock, some resets and noise
  task automatic run_random(int unsigned n);
    int               r;
    logic [TimeW-1:0] now;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + TimeW'($urandom_range(0, 4000));
      now = clock_ms;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send(tbrt_pkg::FUNC_FAIL, now);
      end else if (r < 80) begin
        case ($urandom_range(0, 3))
          0:       now = sb.deadline + TimeW'($urandom_range(0, 4)) - TimeW'(2);
          1:       now = $urandom;
          2:       now = sb.deadline - TimeW'($urandom_range(0, 2000));
          default: ;
        endcase
        send(tbrt_pkg::FUNC_QUERY, now);
      end else if (r < 92) begin
        send(tbrt_pkg::FUNC_RESET, now);
      end else begin
        send(FuncUnused, now);
      end
    end
  endtask

  initial begin
    logic [IdxW-1:0] count;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_func_i   = tbrt_pkg::FUNC_QUERY;
    in_now_ms_i = '0;
    gap_pct     = 20;
    stall_pct   = 20;
    calm        = 1'b0;
    clock_ms    = '0;
    sb          = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Default table: walk the sequence, wrap, saturate, disarm
    send(tbrt_pkg::FUNC_QUERY, 32'd0);
    send(tbrt_pkg::FUNC_FAIL, 32'd0);
    send(tbrt_pkg::FUNC_QUERY, 32'd500);
    send(tbrt_pkg::FUNC_QUERY, 32'd1000);
    send(tbrt_pkg::FUNC_FAIL, 32'hFFFF_FFFF);
    send(tbrt_pkg::FUNC_QUERY, 32'h8000_0000);
    repeat (5) send(tbrt_pkg::FUNC_FAIL, 32'd100);
    send(tbrt_pkg::FUNC_RESET, 32'd0);
    send(tbrt_pkg::FUNC_QUERY, 32'd0);
    // deadline lands on zero
    send(tbrt_pkg::FUNC_FAIL, 32'hFFFF_FC18);
    send(tbrt_pkg::FUNC_QUERY, 32'd0);
    send(FuncUnused, 32'hFFFF_FFFF);

    // Empty table: arm for immediate retry
    wait_idle();
    write_reg(32'(tbrt_pkg::RegEntryCount), '0);
    send(tbrt_pkg::FUNC_FAIL, 32'd1234);
    send(tbrt_pkg::FUNC_QUERY, 32'd1234);
    send(tbrt_pkg::FUNC_FAIL, 32'd0);
    send(tbrt_pkg::FUNC_QUERY, 32'd0);

    // Full table of oversized intervals, then shrink below the attempt index
    wait_idle();
    load_table(3'd7, 1'b1);
    repeat (7) send(tbrt_pkg::FUNC_FAIL, 32'hFFFF_FFFF);
    send(tbrt_pkg::FUNC_QUERY, 32'd0);
    wait_idle();
    write_reg(32'(tbrt_pkg::RegEntryCount), DataW'(3'd2));
    send(tbrt_pkg::FUNC_FAIL, 32'd7);

    // Random phases; the last one runs without input gaps or receiver stalls
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 30;
      endcase
      calm = (phase == NumPhases - 1);
      case ($urandom_range(0, 5))
        0:       count = 3'd0;
        1:       count = 3'd1;
        2:       count = 3'd7;
        default: count = IdxW'($urandom_range(0, 7));
      endcase
      load_table(count, 1'b0);
      run_random(PhaseItems);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tbrt_pkg.sv
src/tbrt_regs.sv
src/table_backoff_retry_timer_unit.sv
sim/tb_top.sv
